// ----- src/clook_pkg.sv -----
// ----------------------------------------------------------------------------
// clook_pkg
// Shared types and constants for the circular-sweep disk request queue.
// ----------------------------------------------------------------------------
`default_nettype none
package clook_pkg;
  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int TRK_W  = 10;
  localparam int TAG_W  = 6;
  localparam int PEND_W = 7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request, zero scan index
    logic rd;       // read entry at scan index
    logic step;     // advance scan index
    logic wr_ins;   // write new request at slot
    logic mv_up;    // move entry idx-1 -> idx (insert shift)
    logic mv_dn;    // move entry idx+1 -> idx (remove shift)
    logic set_idx;  // set scan index to given value
    logic [CNT_W-1:0] idx_val;
    logic cnt_inc;
    logic cnt_dec;
    logic hd_ld;    // reload head register from entry 0
    logic res;      // present result
    logic [1:0] status;
  } clook_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] idx;
    logic             kind;
    logic             rd_hit;  // registered read satisfies current scan test
    logic             rd_ge_h; // registered read track >= head track
    logic             t_gt_h;
    logic             t_eq_h;
  } clook_sts_t;
endpackage
`default_nettype wire

// ----- src/clook_dp.sv -----
// ----------------------------------------------------------------------------
// clook_dp
// Entry memory, scan index, count and head registers.
// ----------------------------------------------------------------------------
`default_nettype none
module clook_dp (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_kind,
  input  wire [clook_pkg::TRK_W-1:0] in_track,
  input  wire [clook_pkg::TAG_W-1:0] in_tag,
  input  wire clook_pkg::clook_cmd_t cmd,
  input  wire                     below_phase,
  output clook_pkg::clook_sts_t   sts,
  output logic                    out_strobe,
  output logic                    out_head_valid,
  output logic [clook_pkg::TRK_W-1:0] out_head_track,
  output logic [clook_pkg::TAG_W-1:0] out_head_tag,
  output logic [clook_pkg::PEND_W-1:0] out_pending,
  output logic [1:0]              out_status
);
  import clook_pkg::*;

  logic [TRK_W-1:0] mem_trk [DEPTH];
  logic [TAG_W-1:0] mem_tag [DEPTH];

  logic [TRK_W-1:0] trk_r, rd_trk_r, hd_trk_r;
  logic [TAG_W-1:0] tag_r, rd_tag_r, hd_tag_r;
  logic             kind_r;
  logic [CNT_W-1:0] cnt_r, idx_r;
  logic             strobe_r;
  logic [1:0]       status_r;

  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             wr_en;
  logic [TRK_W-1:0] wr_trk;
  logic [TAG_W-1:0] wr_tag;

  // read address: idx for scan, idx-1 for insert shift, idx+1 for remove shift, 0 for head reload
  always_comb begin
    rd_addr = idx_r[IDX_W-1:0];
    if (cmd.mv_up) rd_addr = IDX_W'(idx_r - CNT_W'(1));
    if (cmd.mv_dn) rd_addr = IDX_W'(idx_r + CNT_W'(1));
    if (cmd.hd_ld) rd_addr = '0;
  end

  always_comb begin
    wr_en   = cmd.wr_ins | cmd.mv_up | cmd.mv_dn;
    wr_addr = idx_r[IDX_W-1:0];
    wr_trk  = cmd.wr_ins ? trk_r : rd_trk_r;
    wr_tag  = cmd.wr_ins ? tag_r : rd_tag_r;
  end

  // read data registered; moves use the previous cycle's read (pipelined)
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_trk_r <= mem_trk[rd_addr];
      rd_tag_r <= mem_tag[rd_addr];
    end
    if (wr_en) begin
      mem_trk[wr_addr] <= wr_trk;
      mem_tag[wr_addr] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      trk_r  <= in_track;
      tag_r  <= in_tag;
      kind_r <= in_kind;
    end
    if (cmd.hd_ld) begin
      hd_trk_r <= mem_trk[0];
      hd_tag_r <= mem_tag[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      idx_r    <= '0;
      strobe_r <= 1'b0;
      status_r <= ST_OK;
    end else begin
      if (cmd.load)      idx_r <= '0;
      else if (cmd.set_idx) idx_r <= cmd.idx_val;
      else if (cmd.step) idx_r <= idx_r + CNT_W'(1);
      if (cmd.cnt_inc) cnt_r <= cnt_r + CNT_W'(1);
      if (cmd.cnt_dec) cnt_r <= cnt_r - CNT_W'(1);
      strobe_r <= cmd.res;
      if (cmd.res) status_r <= cmd.status;
    end
  end

  always_comb begin
    sts.count   = cnt_r;
    sts.idx     = idx_r;
    sts.kind    = kind_r;
    sts.t_gt_h  = trk_r > hd_trk_r;
    sts.t_eq_h  = trk_r == hd_trk_r;
    sts.rd_ge_h = rd_trk_r >= hd_trk_r;
    if (trk_r > hd_trk_r)       sts.rd_hit = (rd_trk_r >= trk_r) || (rd_trk_r < hd_trk_r);
    else if (trk_r == hd_trk_r) sts.rd_hit = rd_trk_r != hd_trk_r;
    else if (!below_phase)      sts.rd_hit = rd_trk_r < hd_trk_r;
    else                        sts.rd_hit = rd_trk_r > trk_r;
  end

  // head register tracks entry 0; output shows zero when empty
  assign out_strobe     = strobe_r;
  assign out_head_valid = cnt_r != '0;
  assign out_head_track = (cnt_r != '0) ? hd_trk_r : '0;
  assign out_head_tag   = (cnt_r != '0) ? hd_tag_r : '0;
  assign out_pending    = PEND_W'(cnt_r);
  assign out_status     = status_r;
endmodule
`default_nettype wire

// ----- src/clook_ctrl.sv -----
// ----------------------------------------------------------------------------
// clook_ctrl
// Sequencer: slot search, shift, write, head reload, result.
// ----------------------------------------------------------------------------
`default_nettype none
module clook_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  wire clook_pkg::clook_sts_t sts,
  output clook_pkg::clook_cmd_t    cmd,
  output logic                     below_phase
);
  import clook_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DEC   = 8'b0000_0010,
    S_SRD   = 8'b0000_0100, // issue read at idx
    S_SCHK  = 8'b0000_1000, // test registered read
    S_MRD   = 8'b0001_0000, // read for move
    S_MWR   = 8'b0010_0000, // write move
    S_HEAD  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   below_r, below_nxt;
  logic [CNT_W-1:0] slot_r, slot_nxt;
  logic [1:0] st_r, st_nxt;

  assign busy = state_r != S_IDLE;
  assign below_phase = below_r;

  always_comb begin
    state_nxt = state_r;
    below_nxt = below_r;
    slot_nxt  = slot_r;
    st_nxt    = st_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          below_nxt = 1'b0;
          st_nxt    = ST_OK;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.kind == KIND_INSERT) begin
          if (sts.count == CNT_W'(DEPTH)) begin
            st_nxt = ST_FULL; state_nxt = S_DONE;
          end else if (sts.count == '0) begin
            slot_nxt = '0; cmd.set_idx = 1'b1; cmd.idx_val = sts.count;
            state_nxt = S_MRD;
          end else begin
            cmd.set_idx = 1'b1; cmd.idx_val = CNT_W'(1);
            state_nxt = S_SRD;
          end
        end else begin
          if (sts.count == '0) begin
            st_nxt = ST_EMPTY; state_nxt = S_DONE;
          end else begin
            cmd.set_idx = 1'b1; cmd.idx_val = '0;
            state_nxt = S_MRD;
          end
        end
      end
      S_SRD: begin
        if (sts.idx >= sts.count) begin
          slot_nxt = sts.count;
          cmd.set_idx = 1'b1; cmd.idx_val = sts.count;
          state_nxt = S_MRD;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (!sts.t_gt_h && !sts.t_eq_h && !below_r && sts.rd_hit) begin
          // upward run ended; start the wrapped-entry phase at this entry
          below_nxt = 1'b1;
          state_nxt = S_SRD;
          if (sts.rd_ge_h) state_nxt = S_SRD;
        end else if (sts.rd_hit) begin
          slot_nxt = sts.idx;
          cmd.set_idx = 1'b1; cmd.idx_val = sts.count;
          state_nxt = S_MRD;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_MRD: begin
        // insert: shift up from count down to slot; remove: shift down
        if (sts.kind == KIND_INSERT) begin
          if (sts.idx == slot_r) begin
            cmd.wr_ins = 1'b1; cmd.cnt_inc = 1'b1; state_nxt = S_HEAD;
          end else begin
            cmd.mv_up = 1'b1; cmd.rd = 1'b1; state_nxt = S_MWR;
          end
        end else begin
          if (sts.idx + CNT_W'(1) >= sts.count) begin
            cmd.cnt_dec = 1'b1; state_nxt = S_HEAD;
          end else begin
            cmd.mv_dn = 1'b1; cmd.rd = 1'b1; state_nxt = S_MWR;
          end
        end
      end
      S_MWR: begin
        // registered data now holds the source entry; write it
        if (sts.kind == KIND_INSERT) begin
          cmd.mv_up = 1'b1;
          cmd.set_idx = 1'b1; cmd.idx_val = sts.idx - CNT_W'(1);
        end else begin
          cmd.mv_dn = 1'b1;
          cmd.step  = 1'b1;
        end
        state_nxt = S_MRD;
      end
      S_HEAD: begin
        cmd.hd_ld = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.res    = 1'b1;
        cmd.status = st_r;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      below_r <= 1'b0;
      slot_r  <= '0;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      below_r <= below_nxt;
      slot_r  <= slot_nxt;
      st_r    <= st_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_res_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res |=> !cmd.res) else $error("double result");
  a_inc_dec: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.cnt_inc && cmd.cnt_dec)) else $error("count inc and dec together");
endmodule
`default_nettype wire

// ----- src/circular_look_disk_request_queue_top.sv -----
// ----------------------------------------------------------------------------
// circular_look_disk_request_queue_top
// Circular one-direction disk request queue with sorted insert.
// ----------------------------------------------------------------------------
// Usage: raise start with in_kind/in_track/in_tag while busy is low. Insert
// (kind 0) walks the stored entries from the head to find the slot, then
// shifts later entries up one place; remove (kind 1) shifts all
// entries down one. One result per request: out_strobe is high for one
// cycle with the new head, pending count and status. The receiver cannot
// stall; the result is lost if not taken.
// busy drops in the strobe cycle, so the next request can be accepted then.
// Reset empties the queue (count zero); stored entries are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module circular_look_disk_request_queue_top (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  wire        in_kind,
  input  wire [9:0]  in_track,
  input  wire [5:0]  in_tag,
  output logic       out_strobe,
  output logic       out_head_valid,
  output logic [9:0] out_head_track,
  output logic [5:0] out_head_tag,
  output logic [6:0] out_pending,
  output logic [1:0] out_status
);
  import clook_pkg::*;

  clook_cmd_t cmd;
  clook_sts_t sts;
  logic       below;

  clook_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .sts(sts), .cmd(cmd), .below_phase(below)
  );

  clook_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_kind(in_kind), .in_track(in_track), .in_tag(in_tag),
    .cmd(cmd), .below_phase(below), .sts(sts),
    .out_strobe(out_strobe), .out_head_valid(out_head_valid),
    .out_head_track(out_head_track), .out_head_tag(out_head_tag),
    .out_pending(out_pending), .out_status(out_status)
  );
endmodule
`default_nettype wire

// ----- tb/sv/tb_circular_look_disk_request_queue_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_look_disk_request_queue_top
// Drives insert/remove requests into the circular-sweep disk queue, keeps a
// service-order model of the queue and checks every result strobe against it.
// ----------------------------------------------------------------------------
module tb_circular_look_disk_request_queue_top;
  import clook_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [9:0] track;
    logic [5:0] tag;
  } disk_req_t;

  typedef struct packed {
    logic       head_valid;
    logic [9:0] head_track;
    logic [5:0] head_tag;
    logic [6:0] pending;
    logic [1:0] status;
  } head_rpt_t;

  localparam int WATCHDOG_LIMIT = 4000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       in_kind = 1'b0;
  logic [9:0] in_track = '0;
  logic [5:0] in_tag = '0;
  logic       busy, out_strobe, out_head_valid;
  logic [9:0] out_head_track;
  logic [5:0] out_head_tag;
  logic [6:0] out_pending;
  logic [1:0] out_status;

  circular_look_disk_request_queue_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_track(in_track), .in_tag(in_tag),
    .out_strobe(out_strobe), .out_head_valid(out_head_valid),
    .out_head_track(out_head_track), .out_head_tag(out_head_tag),
    .out_pending(out_pending), .out_status(out_status)
  );

  always #5 clk = ~clk;

  disk_req_t req_queue[$];
  head_rpt_t expected_heads[$];
  logic [9:0] q_track[$];
  logic [5:0] q_tag[$];
  int  err_count = 0;
  int  gap_pct = 20;
  bit  hold_off = 1'b0;
  bit  stim_done = 1'b0;
  int  idle_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $time);
    err_count++;
  endtask

  function automatic int service_slot(input logic [9:0] t);
    int n;
    int i;
    logic [9:0] h;
    n = q_track.size();
    if (n == 0) return 0;
    h = q_track[0];
    if (t > h) begin
      for (i = 1; i < n; i++)
        if (q_track[i] >= t || q_track[i] < h) return i;
      return n;
    end
    if (t == h) begin
      for (i = 1; i < n; i++)
        if (q_track[i] != h) return i;
      return n;
    end
    i = 1;
    while (i < n && q_track[i] >= h) i++;
    while (i < n && q_track[i] <= t) i++;
    return i;
  endfunction

  function automatic head_rpt_t apply_request(input disk_req_t r);
    head_rpt_t e;
    int pos;
    e.status = ST_OK;
    if (r.kind == KIND_INSERT) begin
      if (q_track.size() >= DEPTH) e.status = ST_FULL;
      else begin
        pos = service_slot(r.track);
        q_track.insert(pos, r.track);
        q_tag.insert(pos, r.tag);
      end
    end else begin
      if (q_track.size() == 0) e.status = ST_EMPTY;
      else begin
        void'(q_track.pop_front());
        void'(q_tag.pop_front());
      end
    end
    e.head_valid = q_track.size() > 0;
    e.head_track = e.head_valid ? q_track[0] : '0;
    e.head_tag   = e.head_valid ? q_tag[0] : '0;
    e.pending    = 7'(q_track.size());
    return e;
  endfunction

  // driver: holds start until accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_heads.push_back(apply_request('{in_kind, in_track, in_tag}));
      end
      if (!(start && busy)) begin
        if (req_queue.size() > 0 && !hold_off && $urandom_range(99) >= gap_pct) begin
          disk_req_t r;
          r = req_queue.pop_front();
          start <= 1'b1;
          in_kind <= r.kind;
          in_track <= r.track;
          in_tag <= r.tag;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_heads.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          head_rpt_t e;
          e = expected_heads.pop_front();
          if (out_head_valid !== e.head_valid)
            report_mismatch("head_valid", out_head_valid, e.head_valid);
          if (out_head_track !== e.head_track)
            report_mismatch("head_track", out_head_track, e.head_track);
          if (out_head_tag !== e.head_tag)
            report_mismatch("head_tag", out_head_tag, e.head_tag);
          if (out_pending !== e.pending)
            report_mismatch("pending", out_pending, e.pending);
          if (out_status !== e.status)
            report_mismatch("status", out_status, e.status);
        end
      end
      if (out_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("[circular_look_disk_request_queue_top] ERROR");
        $finish;
      end
    end
  end

  function automatic disk_req_t mk(input logic k, input int t, input int g);
    disk_req_t r;
    r.kind = k;
    r.track = 10'(t);
    r.tag = 6'(g);
    return r;
  endfunction

  // well-formed traffic: mostly inserts until near full, then drain
  task automatic add_random(input int count);
    int i;
    int occ;
    int p_ins;
    occ = 0;
    for (i = 0; i < count; i++) begin
      p_ins = (occ < 8) ? 75 : (occ > 56 ? 35 : 55);
      if ($urandom_range(99) < 5) p_ins = 90;  // push toward full
      if ($urandom_range(99) < p_ins) begin
        // narrow range now and then for duplicate tracks
        if ($urandom_range(3) == 0)
          req_queue.push_back(mk(KIND_INSERT, $urandom_range(520, 500), $urandom));
        else
          req_queue.push_back(mk(KIND_INSERT, $urandom_range(1023), $urandom));
        if (occ < DEPTH) occ++;
      end else begin
        req_queue.push_back(mk(KIND_REMOVE, $urandom, $urandom));
        if (occ > 0) occ--;
      end
    end
  endtask

  task automatic wait_drained;
    while (req_queue.size() > 0 || start || expected_heads.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int i;
    // directed: empty remove, head/above/equal/below/wrap inserts, extremes
    req_queue.push_back(mk(KIND_REMOVE, 0, 0));
    req_queue.push_back(mk(KIND_INSERT, 500, 1));
    req_queue.push_back(mk(KIND_INSERT, 700, 2));
    req_queue.push_back(mk(KIND_INSERT, 600, 3));
    req_queue.push_back(mk(KIND_INSERT, 500, 4));
    req_queue.push_back(mk(KIND_INSERT, 100, 5));
    req_queue.push_back(mk(KIND_INSERT, 0, 63));
    req_queue.push_back(mk(KIND_INSERT, 1023, 0));
    req_queue.push_back(mk(KIND_INSERT, 300, 42));
    req_queue.push_back(mk(KIND_INSERT, 100, 21));
    req_queue.push_back(mk(KIND_REMOVE, 1023, 63));
    req_queue.push_back(mk(KIND_REMOVE, 0, 0));
    req_queue.push_back(mk(KIND_INSERT, 800, 7));
    for (i = 0; i < 11; i++) req_queue.push_back(mk(KIND_REMOVE, 0, 0));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // fill to full and overflow, then drain past empty
    for (i = 0; i < DEPTH + 2; i++)
      req_queue.push_back(mk(KIND_INSERT, $urandom_range(1023), $urandom));
    for (i = 0; i < DEPTH + 2; i++) req_queue.push_back(mk(KIND_REMOVE, 0, 0));
    wait_drained();

    gap_pct = 20;
    add_random(500);
    wait_drained();
    hold_off = 1'b1;
    repeat ($urandom_range(30, 5)) @(posedge clk);
    hold_off = 1'b0;
    gap_pct = 60;
    add_random(500);
    wait_drained();
    gap_pct = 0;
    add_random(500);
    wait_drained();
    stim_done = 1'b1;
    repeat (4 * DEPTH + 10) @(posedge clk);
    if (err_count == 0 && expected_heads.size() == 0) begin
      $display("[circular_look_disk_request_queue_top] OK");
    end else begin
      $display("[circular_look_disk_request_queue_top] ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
src/clook_pkg.sv
src/clook_dp.sv
src/clook_ctrl.sv
src/circular_look_disk_request_queue_top.sv
tb/sv/tb_circular_look_disk_request_queue_top.sv
